### rtl/lbm_pkg.sv
package lbm_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL   = 3'd0,
    MODE_MULTIPLY = 3'd1,
    MODE_SCREEN   = 3'd2,
    MODE_OVERLAY  = 3'd3,
    MODE_DARKEN   = 3'd4,
    MODE_LIGHTEN  = 3'd5,
    MODE_DIFF     = 3'd6
  } mode_e;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_BLEND_MODE = 2'd0;
  localparam logic [1:0] REG_OPACITY    = 2'd1;
  localparam logic [1:0] REG_VISIBLE    = 2'd2;

  localparam int unsigned ADDR_W = 4;

  localparam logic [2:0] BLEND_MODE_RST = 3'd0;
  localparam logic [6:0] OPACITY_RST    = 7'd100;
  localparam logic       VISIBLE_RST    = 1'b1;

  localparam logic [6:0] OPACITY_FULL = 7'd100;

  // x / 100 as (x * RECIP_100) >> RECIP_SHIFT, exact for x up to 25500
  localparam logic [15:0] RECIP_100   = 16'd41944;
  localparam int unsigned RECIP_SHIFT = 22;

  localparam int unsigned PIPE_DEPTH = 4;

  typedef struct packed {
    mode_e      mode;
    logic [6:0] opacity;   // saturated, forced to zero for a hidden layer
  } cfg_t;

endpackage

### rtl/layer_blend_mode_alpha_mix.sv
// channel   direction  handshake                    payload
// pixel in  input      start high, busy low         bg_*_i, fg_*_i (8 bits each)
// pixel out output     out_valid_o for one cycle    out_*_o (8 bits each)
// config    input      apb, psel/penable/pwrite     paddr, pwdata, prdata
//
// one pixel is taken every clock; each result is registered through the four
// register stages of the channel pipeline
// (products, blend select, opacity mix, reciprocal divide by one hundred).
// busy is held low: the receiver cannot stall, so nothing ever waits.
// reset clears the valid bits and restores the register defaults.
module layer_blend_mode_alpha_mix (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [7:0]                  bg_red_i,
  input  logic [7:0]                  bg_green_i,
  input  logic [7:0]                  bg_blue_i,
  input  logic [7:0]                  fg_red_i,
  input  logic [7:0]                  fg_green_i,
  input  logic [7:0]                  fg_blue_i,
  output logic                        out_valid_o,
  output logic [7:0]                  out_red_o,
  output logic [7:0]                  out_green_o,
  output logic [7:0]                  out_blue_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lbm_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  lbm_pkg::cfg_t cfg;
  logic [lbm_pkg::PIPE_DEPTH-1:0] valid_q, valid_d;

  assign busy = 1'b0;

  lbm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // valid bits follow the data through the stages
  assign valid_d = {valid_q[lbm_pkg::PIPE_DEPTH-2:0], start && !busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign out_valid_o = valid_q[lbm_pkg::PIPE_DEPTH-1];

  lbm_channel u_red (
    .clk_i (clk_i),
    .cfg_i (cfg),
    .bg_i  (bg_red_i),
    .fg_i  (fg_red_i),
    .out_o (out_red_o)
  );

  lbm_channel u_green (
    .clk_i (clk_i),
    .cfg_i (cfg),
    .bg_i  (bg_green_i),
    .fg_i  (fg_green_i),
    .out_o (out_green_o)
  );

  lbm_channel u_blue (
    .clk_i (clk_i),
    .cfg_i (cfg),
    .bg_i  (bg_blue_i),
    .fg_i  (fg_blue_i),
    .out_o (out_blue_o)
  );

endmodule

### rtl/lbm_cfg_regs.sv
module lbm_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lbm_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output lbm_pkg::cfg_t               cfg_o
);

  logic [2:0] blend_mode_q, blend_mode_d;
  logic [6:0] opacity_q, opacity_d;
  logic       visible_q, visible_d;
  logic       wr_en;
  logic [6:0] opacity_sat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    blend_mode_d = blend_mode_q;
    opacity_d    = opacity_q;
    visible_d    = visible_q;
    if (wr_en) begin
      case (paddr[3:2])
        lbm_pkg::REG_BLEND_MODE: blend_mode_d = pwdata[2:0];
        lbm_pkg::REG_OPACITY:    opacity_d    = pwdata[6:0];
        lbm_pkg::REG_VISIBLE:    visible_d    = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blend_mode_q <= lbm_pkg::BLEND_MODE_RST;
      opacity_q    <= lbm_pkg::OPACITY_RST;
      visible_q    <= lbm_pkg::VISIBLE_RST;
    end else begin
      blend_mode_q <= blend_mode_d;
      opacity_q    <= opacity_d;
      visible_q    <= visible_d;
    end
  end

  always_comb begin
    case (paddr[3:2])
      lbm_pkg::REG_BLEND_MODE: prdata = {29'd0, blend_mode_q};
      lbm_pkg::REG_OPACITY:    prdata = {25'd0, opacity_q};
      lbm_pkg::REG_VISIBLE:    prdata = {31'd0, visible_q};
      default:                 prdata = 32'd0;
    endcase
  end

  // a hidden layer is a zero opacity mix, which returns the background exactly
  assign opacity_sat = (opacity_q > lbm_pkg::OPACITY_FULL) ? lbm_pkg::OPACITY_FULL : opacity_q;
  assign cfg_o.mode    = lbm_pkg::mode_e'(blend_mode_q);
  assign cfg_o.opacity = visible_q ? opacity_sat : 7'd0;

endmodule

### rtl/lbm_channel.sv
module lbm_channel (
  input  logic          clk_i,
  input  lbm_pkg::cfg_t cfg_i,
  input  logic [7:0]    bg_i,
  input  logic [7:0]    fg_i,
  output logic [7:0]    out_o
);

  // stage 1: products and compare
  logic [15:0] mul_q, inv_q;
  logic [7:0]  bg1_q, fg1_q;
  logic        lt1_q;
  // stage 2: blended value
  logic [7:0]  c_q, c_d, bg2_q;
  // stage 3: opacity mix
  logic [14:0] mix_q, mix_d;
  // stage 4: reciprocal product
  logic [30:0] quo_q;

  logic [7:0]  inv_bg, inv_fg;
  logic [7:0]  ovl_lo, ovl_hi;
  logic [6:0]  p_inv;

  assign inv_bg = 8'd255 - bg_i;
  assign inv_fg = 8'd255 - fg_i;

  always_ff @(posedge clk_i) begin
    mul_q <= bg_i * fg_i;
    inv_q <= inv_bg * inv_fg;
    bg1_q <= bg_i;
    fg1_q <= fg_i;
    lt1_q <= bg_i < fg_i;
  end

  // both overlay products shifted by 7 stay at most 253, so bit 15 is never needed
  assign ovl_lo = mul_q[14:7];
  assign ovl_hi = 8'd255 - inv_q[14:7];

  always_comb begin
    case (cfg_i.mode)
      lbm_pkg::MODE_MULTIPLY: c_d = mul_q[15:8];
      lbm_pkg::MODE_SCREEN:   c_d = 8'd255 - inv_q[15:8];
      lbm_pkg::MODE_OVERLAY:  c_d = bg1_q[7] ? ovl_hi : ovl_lo;
      lbm_pkg::MODE_DARKEN:   c_d = lt1_q ? bg1_q : fg1_q;
      lbm_pkg::MODE_LIGHTEN:  c_d = lt1_q ? fg1_q : bg1_q;
      lbm_pkg::MODE_DIFF:     c_d = lt1_q ? (fg1_q - bg1_q) : (bg1_q - fg1_q);
      default:                c_d = fg1_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    c_q   <= c_d;
    bg2_q <= bg1_q;
  end

  assign p_inv = lbm_pkg::OPACITY_FULL - cfg_i.opacity;

  // at most 100 * 255, fits in 15 bits
  assign mix_d = 15'(cfg_i.opacity * c_q) + 15'(p_inv * bg2_q);

  always_ff @(posedge clk_i) begin
    mix_q <= mix_d;
    quo_q <= 31'(mix_q * lbm_pkg::RECIP_100);
  end

  assign out_o = quo_q[lbm_pkg::RECIP_SHIFT +: 8];

endmodule
